// ----- design/fun_pkg.sv -----
// Shared types and constants for the face unit normal block.
`default_nettype none
package fun_pkg;

    // Field widths of the transfers.
    localparam int COORD_WIDTH      = 16;
    localparam int NORMAL_FRAC_BITS = 14;
    localparam int NORMAL_WIDTH     = NORMAL_FRAC_BITS + 2;

    // Internal arithmetic widths.
    localparam int EDGE_W  = COORD_WIDTH + 1;
    localparam int PROD_W  = 2 * EDGE_W;
    localparam int CROSS_W = PROD_W + 1;
    localparam int MAG_W   = PROD_W;
    localparam int LIMIT_EXP = 30;
    localparam int A_W     = (MAG_W < LIMIT_EXP) ? MAG_W : LIMIT_EXP;
    localparam int KMAX    = MAG_W - A_W;
    localparam int K_W     = (KMAX > 0) ? $clog2(KMAX + 1) : 1;
    localparam int SQ_W    = 2 * A_W;
    localparam int S_W     = SQ_W + 2;
    localparam int T_W     = S_W + 2 * NORMAL_FRAC_BITS + 2;
    localparam int Q_W     = NORMAL_FRAC_BITS + 1;
    localparam int NUM_CELLS = NORMAL_FRAC_BITS + 1;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] ax;
        logic signed [COORD_WIDTH-1:0] ay;
        logic signed [COORD_WIDTH-1:0] az;
        logic signed [COORD_WIDTH-1:0] bx;
        logic signed [COORD_WIDTH-1:0] by;
        logic signed [COORD_WIDTH-1:0] bz;
        logic signed [COORD_WIDTH-1:0] cx;
        logic signed [COORD_WIDTH-1:0] cy;
        logic signed [COORD_WIDTH-1:0] cz;
    } fun_in_t;

    typedef struct packed {
        logic signed [NORMAL_WIDTH-1:0] nx;
        logic signed [NORMAL_WIDTH-1:0] ny;
        logic signed [NORMAL_WIDTH-1:0] nz;
        logic                           degenerate;
    } fun_out_t;

    // One component as it travels down the row of cells.
    typedef struct packed {
        logic [T_W-1:0] p;
        logic [T_W-1:0] qsh;
        logic [T_W-1:0] r;
        logic [Q_W-1:0] q;
        logic           neg;
    } fun_lane_t;

    typedef struct packed {
        logic [T_W-1:0] s2;
        logic [Q_W-1:0] bitm;
        logic           degen;
        fun_lane_t [2:0] lane;
    } fun_cell_t;

endpackage
`default_nettype wire

// ----- design/fun_cell.sv -----
// One cell of the row: settles one quotient bit of all three components.
`default_nettype none
module fun_cell (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire fun_pkg::fun_cell_t in_data,
    output logic                out_valid,
    input  wire logic           out_ready,
    output fun_pkg::fun_cell_t  out_data
);
    logic                valid_reg;
    fun_pkg::fun_cell_t  data_reg;
    fun_pkg::fun_cell_t  data_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // Trial bit: accept it if the grown square does not exceed the bound and the top quotient bit is still clear.
    always_comb begin
        logic [fun_pkg::T_W-1:0] t;
        logic                    ok;
        logic [fun_pkg::T_W-1:0] qn;
        data_next = in_data;
        for (int i = 0; i < 3; i++) begin
            t  = in_data.lane[i].p + in_data.lane[i].qsh + in_data.s2;
            ok = (t <= in_data.lane[i].r) && !in_data.lane[i].q[fun_pkg::Q_W-1];
            qn = ok ? in_data.lane[i].qsh + (in_data.s2 << 1) : in_data.lane[i].qsh;
            data_next.lane[i].p   = ok ? t : in_data.lane[i].p;
            data_next.lane[i].qsh = qn >> 1;
            data_next.lane[i].q   = ok ? (in_data.lane[i].q | in_data.bitm)
                                       : in_data.lane[i].q;
        end
        data_next.s2   = in_data.s2 >> 2;
        data_next.bitm = in_data.bitm >> 1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end
endmodule
`default_nettype wire

// ----- design/fun_front.sv -----
// Front pipeline: edges, cross product, scaling and squared lengths.
`default_nettype none
module fun_front (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire fun_pkg::fun_in_t in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output fun_pkg::fun_cell_t    out_data
);
    localparam int NST = 7;

    logic [NST:1] v_reg;
    logic [NST+1:1] rdy;

    // Stage payloads.
    logic signed [fun_pkg::EDGE_W-1:0]  e1_reg [3];
    logic signed [fun_pkg::EDGE_W-1:0]  e2_reg [3];
    logic signed [fun_pkg::PROD_W-1:0]  pr_reg [6];
    logic [fun_pkg::MAG_W-1:0]          mag3_reg [3];
    logic [2:0]                         neg3_reg;
    logic                               zero3_reg;
    logic [fun_pkg::MAG_W-1:0]          mag4_reg [3];
    logic [fun_pkg::MAG_W-1:0]          max4_reg;
    logic [2:0]                         neg4_reg;
    logic                               zero4_reg;
    logic [fun_pkg::A_W-1:0]            a5_reg [3];
    logic [2:0]                         neg5_reg;
    logic                               zero5_reg;
    logic [fun_pkg::SQ_W-1:0]           sq6_reg [3];
    logic [2:0]                         neg6_reg;
    logic                               zero6_reg;
    fun_pkg::fun_cell_t                 cell7_reg;

    // Ready ripples back from the cells; a stage takes data when empty or moving on.
    always_comb begin
        rdy[NST+1] = out_ready;
        for (int j = NST; j >= 1; j--) begin
            rdy[j] = !v_reg[j] || rdy[j+1];
        end
    end
    assign in_ready  = rdy[1];
    assign out_valid = v_reg[NST];
    assign out_data  = cell7_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (rdy[1]) begin
                v_reg[1] <= in_valid;
            end
            for (int j = 2; j <= NST; j++) begin
                if (rdy[j]) begin
                    v_reg[j] <= v_reg[j-1];
                end
            end
        end
    end

    // Stage 1: edge vectors.
    always_ff @(posedge aclk) begin
        if (rdy[1] && in_valid) begin
            e1_reg[0] <= fun_pkg::EDGE_W'(in_data.bx) - fun_pkg::EDGE_W'(in_data.ax);
            e1_reg[1] <= fun_pkg::EDGE_W'(in_data.by) - fun_pkg::EDGE_W'(in_data.ay);
            e1_reg[2] <= fun_pkg::EDGE_W'(in_data.bz) - fun_pkg::EDGE_W'(in_data.az);
            e2_reg[0] <= fun_pkg::EDGE_W'(in_data.cx) - fun_pkg::EDGE_W'(in_data.ax);
            e2_reg[1] <= fun_pkg::EDGE_W'(in_data.cy) - fun_pkg::EDGE_W'(in_data.ay);
            e2_reg[2] <= fun_pkg::EDGE_W'(in_data.cz) - fun_pkg::EDGE_W'(in_data.az);
        end
    end

    // Stage 2: the six partial products of the cross product.
    always_ff @(posedge aclk) begin
        if (rdy[2] && v_reg[1]) begin
            pr_reg[0] <= fun_pkg::PROD_W'(e1_reg[1]) * fun_pkg::PROD_W'(e2_reg[2]);
            pr_reg[1] <= fun_pkg::PROD_W'(e1_reg[2]) * fun_pkg::PROD_W'(e2_reg[1]);
            pr_reg[2] <= fun_pkg::PROD_W'(e1_reg[2]) * fun_pkg::PROD_W'(e2_reg[0]);
            pr_reg[3] <= fun_pkg::PROD_W'(e1_reg[0]) * fun_pkg::PROD_W'(e2_reg[2]);
            pr_reg[4] <= fun_pkg::PROD_W'(e1_reg[0]) * fun_pkg::PROD_W'(e2_reg[1]);
            pr_reg[5] <= fun_pkg::PROD_W'(e1_reg[1]) * fun_pkg::PROD_W'(e2_reg[0]);
        end
    end

    // Stage 3: cross components split into sign and magnitude.
    always_ff @(posedge aclk) begin
        logic signed [fun_pkg::CROSS_W-1:0] n;
        logic [2:0]                         nz;
        if (rdy[3] && v_reg[2]) begin
            for (int i = 0; i < 3; i++) begin
                n = fun_pkg::CROSS_W'(pr_reg[2*i]) - fun_pkg::CROSS_W'(pr_reg[2*i+1]);
                neg3_reg[i] <= n[fun_pkg::CROSS_W-1];
                mag3_reg[i] <= n[fun_pkg::CROSS_W-1] ? fun_pkg::MAG_W'(-n)
                                                     : fun_pkg::MAG_W'(n);
                nz[i] = (n != '0);
            end
            zero3_reg <= (nz == 3'b000);
        end
    end

    // Stage 4: largest magnitude.
    always_ff @(posedge aclk) begin
        logic [fun_pkg::MAG_W-1:0] mx;
        if (rdy[4] && v_reg[3]) begin
            mx = mag3_reg[0];
            if (mag3_reg[1] > mx) begin
                mx = mag3_reg[1];
            end
            if (mag3_reg[2] > mx) begin
                mx = mag3_reg[2];
            end
            max4_reg  <= mx;
            mag4_reg  <= mag3_reg;
            neg4_reg  <= neg3_reg;
            zero4_reg <= zero3_reg;
        end
    end

    // Stage 5: scale all magnitudes below the limit by a common right shift.
    always_ff @(posedge aclk) begin
        logic [fun_pkg::K_W-1:0] ksel;
        if (rdy[5] && v_reg[4]) begin
            ksel = fun_pkg::K_W'(fun_pkg::KMAX);
            for (int k = fun_pkg::KMAX - 1; k >= 0; k--) begin
                if (max4_reg < (fun_pkg::MAG_W'(1) << (fun_pkg::A_W + k))) begin
                    ksel = fun_pkg::K_W'(k);
                end
            end
            for (int i = 0; i < 3; i++) begin
                a5_reg[i] <= fun_pkg::A_W'(mag4_reg[i] >> ksel);
            end
            neg5_reg  <= neg4_reg;
            zero5_reg <= zero4_reg;
        end
    end

    // Stage 6: squares of the scaled magnitudes.
    always_ff @(posedge aclk) begin
        if (rdy[6] && v_reg[5]) begin
            for (int i = 0; i < 3; i++) begin
                sq6_reg[i] <= fun_pkg::SQ_W'(a5_reg[i]) * fun_pkg::SQ_W'(a5_reg[i]);
            end
            neg6_reg  <= neg5_reg;
            zero6_reg <= zero5_reg;
        end
    end

    // Stage 7: squared length and the starting payload of the cell row.
    always_ff @(posedge aclk) begin
        logic [fun_pkg::S_W-1:0] s;
        if (rdy[7] && v_reg[6]) begin
            s = fun_pkg::S_W'(sq6_reg[0]) + fun_pkg::S_W'(sq6_reg[1])
              + fun_pkg::S_W'(sq6_reg[2]);
            cell7_reg.s2    <= fun_pkg::T_W'(s) << (2 * fun_pkg::NORMAL_FRAC_BITS);
            cell7_reg.bitm  <= fun_pkg::Q_W'(1) << fun_pkg::NORMAL_FRAC_BITS;
            cell7_reg.degen <= zero6_reg;
            for (int i = 0; i < 3; i++) begin
                cell7_reg.lane[i].p   <= '0;
                cell7_reg.lane[i].qsh <= '0;
                cell7_reg.lane[i].r   <= fun_pkg::T_W'(sq6_reg[i])
                                         << (2 * fun_pkg::NORMAL_FRAC_BITS);
                cell7_reg.lane[i].q   <= '0;
                cell7_reg.lane[i].neg <= neg6_reg[i];
            end
        end
    end
endmodule
`default_nettype wire

// ----- design/face_unit_normal.sv -----
// Top level of the face unit normal block.
// Takes one triangle face per cycle when not held by backpressure (three signed
// vertex positions) and returns its unit normal in Q1.14, truncated toward zero,
// with a degenerate flag for a zero cross product. The result passes through
// seven front stages (edges, products, cross components, maximum, scaling,
// squares, squared length), one cell per quotient bit (15 cells), and the
// output register. Backpressure on the result side stalls only the stages that
// are full, so bubbles are squeezed out.
`default_nettype none
module face_unit_normal (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire fun_pkg::fun_in_t  s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output fun_pkg::fun_out_t      m_data
);
    localparam int NC = fun_pkg::NUM_CELLS;

    logic               cv   [NC+1];
    logic               crdy [NC+1];
    fun_pkg::fun_cell_t cd   [NC+1];

    logic               m_valid_reg;
    fun_pkg::fun_out_t  m_data_reg;
    fun_pkg::fun_out_t  m_data_next;
    logic               last_ready;

    fun_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .out_valid (cv[0]),
        .out_ready (crdy[0]),
        .out_data  (cd[0])
    );

    // Row of cells, most significant quotient bit first.
    for (genvar g = 0; g < NC; g++) begin : g_cell
        fun_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (cv[g]),
            .in_ready  (crdy[g]),
            .in_data   (cd[g]),
            .out_valid (cv[g+1]),
            .out_ready (crdy[g+1]),
            .out_data  (cd[g+1])
        );
    end

    assign last_ready = !m_valid_reg || m_ready;
    assign crdy[NC]   = last_ready;

    // Apply signs; a degenerate face gives an all-zero normal.
    always_comb begin
        logic [fun_pkg::NORMAL_WIDTH-1:0] mg [3];
        logic [fun_pkg::NORMAL_WIDTH-1:0] nv [3];
        for (int i = 0; i < 3; i++) begin
            mg[i] = fun_pkg::NORMAL_WIDTH'(cd[NC].lane[i].q);
            nv[i] = cd[NC].degen ? '0 : (cd[NC].lane[i].neg ? -mg[i] : mg[i]);
        end
        m_data_next.nx         = nv[0];
        m_data_next.ny         = nv[1];
        m_data_next.nz         = nv[2];
        m_data_next.degenerate = cd[NC].degen;
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (last_ready) begin
            m_valid_reg <= cv[NC];
        end
    end

    always_ff @(posedge aclk) begin
        if (last_ready && cv[NC]) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
endmodule
`default_nettype wire
